// ===== rtl/dcc_pkg.sv =====
// shared types and constants of the diverging colormap
// no dependencies; used by dcc_in_if and by every rtl module of the block but dcc_checker

package dcc_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned VALUE_WIDTH_DEF     = 32;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 16;

  // hue endpoints in degrees, and the width of one hsv sector
  localparam int unsigned HUE_START_DEG   = 120;
  localparam int unsigned HUE_NEG_END_DEG = 240;
  localparam int unsigned SECTOR_DEG      = 60;

  // the same, in units of one sector
  localparam int unsigned HS_START = HUE_START_DEG / SECTOR_DEG;
  localparam int unsigned HS_SPAN  = (HUE_NEG_END_DEG - HUE_START_DEG) / SECTOR_DEG;

  // configuration register index
  typedef enum logic {
    REG_NEG_LIMIT,
    REG_POS_LIMIT
  } reg_idx_e;

  // per-stage control that travels with the data
  typedef struct packed {
    logic valid;  // stage holds a request
    logic neg;    // sample was negative
    logic sat;    // ratio is exactly one
  } dcc_ctl_t;

endpackage

// ===== rtl/dcc_in_if.sv =====
// input stream channel of the diverging colormap: valid, ready, sample
// depends on dcc_pkg for the default sample width

interface dcc_in_if #(
  parameter int unsigned VALUE_WIDTH = dcc_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== rtl/dcc_out_if.sv =====
// output stream channel of the diverging colormap: valid, ready, rgb bytes
// no dependencies

interface dcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/diverging_curvature_colormap.sv =====
// diverging colormap top level: apb limits, input stage, divider chain, color stages
// depends on dcc_pkg, dcc_in_if, dcc_out_if, dcc_cfg, dcc_div_step and dcc_color
//
// usage
//   in_i carries one signed q16.16 sample per request; out_o returns one rgb
//   color per request, in order. negatives shade from green toward blue by
//   |sample|/|neg_limit|, the rest from green toward red by sample/pos_limit;
//   the ratio saturates at one, and a zero limit means full blue or full red
//   the user writes limits over apb (neg_limit at index 0, pos_limit at index 1)
//   only while no request is in flight, unchecked by the block; pready is tied high
// pipeline and throughput
//   a taken request passes one input stage, one divider stage per ratio bit,
//   a hue/sector stage and the byte-rounding output register on its way to out_o
//   one request per cycle sustained while out_o does not stall; the divider
//   is fully unrolled into stages, one quotient bit each
// reset and stall
//   reset clears both limits and every stage valid bit; out_o is idle after
//   reset. when out_o stalls with a result held, the whole pipe freezes and
//   in_i.ready drops in the same cycle; nothing is lost or repeated

module diverging_curvature_colormap #(
  parameter int unsigned VALUE_WIDTH     = dcc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned RATIO_FRAC_BITS = dcc_pkg::RATIO_FRAC_BITS_DEF,
  localparam int unsigned DATA_W         = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int unsigned ADDR_W         = (VALUE_WIDTH > 32) ? 4 : 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  dcc_in_if.sink            in_i,
  dcc_out_if.source         out_o
);
  import dcc_pkg::*;

  localparam int unsigned W = VALUE_WIDTH;
  localparam int unsigned F = RATIO_FRAC_BITS;

  // limit registers
  logic signed [W-1:0] neg_limit;
  logic [W-2:0]        pos_limit;

  // pipe advances whenever the output register is empty or being drained
  logic adv;
  logic out_valid;

  // input stage
  logic [W-1:0] sample_u, neg_lim_u;
  logic [W-1:0] mag_d, neg_mag, lim_d;
  logic         neg_d;
  dcc_ctl_t     a_ctl_d, a_ctl_q;
  logic [W-1:0] a_rem_q, a_lim_q;

  // divider chain, entry 0 is the input stage
  dcc_ctl_t     ctl_s [F+1];
  logic [W-1:0] rem_s [F+1];
  logic [W-1:0] lim_s [F+1];
  logic [F-1:0] quo_s [F+1];

  dcc_cfg #(
    .VALUE_WIDTH (W),
    .DATA_W      (DATA_W),
    .ADDR_W      (ADDR_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .neg_limit_o (neg_limit),
    .pos_limit_o (pos_limit)
  );

  assign adv        = !out_valid || out_o.ready;
  assign in_i.ready = adv;

  // magnitudes; the most negative value becomes 2^(W-1) exactly
  assign sample_u  = in_i.sample_value;
  assign neg_lim_u = neg_limit;
  assign neg_d     = sample_u[W-1];
  assign mag_d     = neg_d ? (~sample_u + W'(1)) : sample_u;
  assign neg_mag   = neg_lim_u[W-1] ? (~neg_lim_u + W'(1)) : neg_lim_u;
  assign lim_d     = neg_d ? neg_mag : {1'b0, pos_limit};

  always_comb begin
    a_ctl_d.valid = in_i.valid;
    a_ctl_d.neg   = neg_d;
    // zero limit or sample at/beyond full scale gives a ratio of one
    a_ctl_d.sat   = (lim_d == '0) || (mag_d >= lim_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
    end else if (adv) begin
      a_ctl_q <= a_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_rem_q <= mag_d;
      a_lim_q <= lim_d;
    end
  end

  assign ctl_s[0] = a_ctl_q;
  assign rem_s[0] = a_rem_q;
  assign lim_s[0] = a_lim_q;
  assign quo_s[0] = '0;

  // one stage per quotient bit
  for (genvar k = 0; k < F; k++) begin : g_div
    dcc_div_step #(
      .VALUE_WIDTH     (W),
      .RATIO_FRAC_BITS (F)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_s[k]),
      .rem_i  (rem_s[k]),
      .lim_i  (lim_s[k]),
      .quo_i  (quo_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .lim_o  (lim_s[k+1]),
      .quo_o  (quo_s[k+1])
    );
  end

  // hue, sector and rounding; owns the output register
  dcc_color #(
    .RATIO_FRAC_BITS (F)
  ) u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .ctl_i   (ctl_s[F]),
    .quo_i   (quo_s[F]),
    .valid_o (out_valid),
    .red_o   (out_o.red),
    .green_o (out_o.green),
    .blue_o  (out_o.blue)
  );

  assign out_o.valid = out_valid;
endmodule

// ===== rtl/dcc_cfg.sv =====
// apb register file holding the two limit registers
// depends on dcc_pkg for the register index codes

module dcc_cfg #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DATA_W      = 32,
  parameter int unsigned ADDR_W      = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  output logic signed [VALUE_WIDTH-1:0] neg_limit_o,
  output logic [VALUE_WIDTH-2:0]        pos_limit_o
);
  import dcc_pkg::*;

  logic signed [VALUE_WIDTH-1:0] neg_limit_q;
  logic [VALUE_WIDTH-2:0]        pos_limit_q;
  reg_idx_e                      idx;
  logic                          wr_en;

  // two registers, so the top address bit picks one
  assign idx    = reg_idx_e'(paddr[ADDR_W-1]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_limit_q <= '0;
      pos_limit_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_NEG_LIMIT: neg_limit_q <= pwdata[VALUE_WIDTH-1:0];
        REG_POS_LIMIT: pos_limit_q <= pwdata[VALUE_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NEG_LIMIT: prdata = DATA_W'(neg_limit_q);
      REG_POS_LIMIT: prdata = DATA_W'(pos_limit_q);
      default:       prdata = '0;
    endcase
  end

  assign neg_limit_o = neg_limit_q;
  assign pos_limit_o = pos_limit_q;
endmodule

// ===== rtl/dcc_div_step.sv =====
// one registered step of the restoring divider: one quotient bit per stage
// depends on dcc_pkg for the stage control struct

module dcc_div_step #(
  parameter int unsigned VALUE_WIDTH     = 32,
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  dcc_pkg::dcc_ctl_t              ctl_i,
  input  logic [VALUE_WIDTH-1:0]         rem_i,
  input  logic [VALUE_WIDTH-1:0]         lim_i,
  input  logic [RATIO_FRAC_BITS-1:0]     quo_i,
  output dcc_pkg::dcc_ctl_t              ctl_o,
  output logic [VALUE_WIDTH-1:0]         rem_o,
  output logic [VALUE_WIDTH-1:0]         lim_o,
  output logic [RATIO_FRAC_BITS-1:0]     quo_o
);
  import dcc_pkg::*;

  dcc_ctl_t                       ctl_q;
  logic [VALUE_WIDTH-1:0]         rem_q, rem_d;
  logic [VALUE_WIDTH-1:0]         lim_q;
  logic [RATIO_FRAC_BITS-1:0]     quo_q, quo_d;
  logic [VALUE_WIDTH:0]           rem_x2;
  logic [VALUE_WIDTH:0]           rem_sub;
  logic                           ge;

  // remainder stays below the limit, so the doubled value fits one extra bit
  assign rem_x2  = {rem_i, 1'b0};
  assign rem_sub = rem_x2 - {1'b0, lim_i};
  assign ge      = rem_x2 >= {1'b0, lim_i};
  assign rem_d   = ge ? rem_sub[VALUE_WIDTH-1:0] : rem_x2[VALUE_WIDTH-1:0];
  assign quo_d   = {quo_i[RATIO_FRAC_BITS-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      lim_q <= lim_i;
      quo_q <= quo_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign lim_o = lim_q;
  assign quo_o = quo_q;
endmodule

// ===== rtl/dcc_color.sv =====
// hue and hsv sector stage, then byte rounding into the output register
// depends on dcc_pkg for the hue constants and the stage control struct

module dcc_color #(
  parameter int unsigned RATIO_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  dcc_pkg::dcc_ctl_t          ctl_i,
  input  logic [RATIO_FRAC_BITS-1:0] quo_i,
  output logic                       valid_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 blue_o
);
  import dcc_pkg::*;

  localparam int unsigned F    = RATIO_FRAC_BITS;
  localparam int unsigned HS_W = F + 3;

  localparam logic [F:0]      ONE      = {1'b1, {F{1'b0}}};
  localparam logic [HS_W-1:0] HS_ONE   = HS_W'(1) << F;
  localparam logic [HS_W-1:0] HS_TWO   = HS_ONE << 1;
  localparam logic [HS_W-1:0] HS_THREE = HS_ONE + HS_TWO;
  localparam logic [HS_W-1:0] HS_BASE  = HS_W'(HS_START) << F;
  localparam logic [F+8:0]    HALF     = (F+9)'(1) << (F - 1);

  // level in [0,1] to a byte, round half up
  function automatic logic [7:0] to_byte(input logic [F:0] lvl);
    logic [F+8:0] prod;
    prod = {lvl, 8'd0} - {8'd0, lvl};
    prod = prod + HALF;
    return prod[F+7:F];
  endfunction

  logic [F:0]      alpha;
  logic [HS_W-1:0] span, hs;
  logic [F:0]      frac, mid_gap, sec_x;
  logic [F:0]      lvl_r_d, lvl_g_d, lvl_b_d;
  logic [F:0]      lvl_r_q, lvl_g_q, lvl_b_q;
  logic            hue_valid_q;
  logic            valid_q;
  logic [7:0]      red_q, green_q, blue_q;

  assign alpha = ctl_i.sat ? ONE : {1'b0, quo_i};
  assign span  = HS_W'(alpha) * HS_W'(HS_SPAN);
  assign hs    = ctl_i.neg ? (HS_BASE + span) : (HS_BASE - span);

  // secondary component from the distance to the sector middle
  assign frac    = hs[F:0];
  assign mid_gap = (frac >= ONE) ? (frac - ONE) : (ONE - frac);
  assign sec_x   = ONE - mid_gap;

  always_comb begin
    if (hs <= HS_ONE) begin
      lvl_r_d = ONE;   lvl_g_d = sec_x; lvl_b_d = '0;
    end else if (hs <= HS_TWO) begin
      lvl_r_d = sec_x; lvl_g_d = ONE;   lvl_b_d = '0;
    end else if (hs <= HS_THREE) begin
      lvl_r_d = '0;    lvl_g_d = ONE;   lvl_b_d = sec_x;
    end else begin
      lvl_r_d = '0;    lvl_g_d = sec_x; lvl_b_d = ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      hue_valid_q <= ctl_i.valid;
      valid_q     <= hue_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lvl_r_q <= lvl_r_d;
      lvl_g_q <= lvl_g_d;
      lvl_b_q <= lvl_b_d;
      red_q   <= to_byte(lvl_r_q);
      green_q <= to_byte(lvl_g_q);
      blue_q  <= to_byte(lvl_b_q);
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
endmodule

// ===== rtl/dcc_checker.sv =====
// port-level checks of the diverging colormap, bound to the top level
// depends on diverging_curvature_colormap for the bind target

module dcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i
);

  // a held result keeps its color while stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({red_i, green_i, blue_i}))
    else $error("result changed while stalled");

  // input is taken exactly when the output side can move
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output stall");

  // full saturation and value: one channel at full, one at zero
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (red_i == 8'd255 || green_i == 8'd255 || blue_i == 8'd255) &&
                    (red_i == 8'd0 || green_i == 8'd0 || blue_i == 8'd0))
    else $error("color is not fully saturated");

  // hue stays between red and blue through green, never magenta
  a_no_magenta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (red_i == 8'd0 || blue_i == 8'd0))
    else $error("red and blue both lit");

endmodule

bind diverging_curvature_colormap dcc_checker u_dcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red),
  .green_i     (out_o.green),
  .blue_i      (out_o.blue)
);

// ===== tb/dcc_colormap_checker.sv =====
// checker for the diverging colormap: follows apb limit writes, predicts one rgb color
// per accepted sample and compares it with every color taken from the output channel
// depends on dcc_pkg, dcc_in_if and dcc_out_if

module dcc_colormap_checker
  import dcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  dcc_in_if           in_mon,
  dcc_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned samples_o
);

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned FB = RATIO_FRAC_BITS_DEF;
  localparam logic [63:0] UNITY = 64'd1 << FB;
  // far more than the pipe can hold in flight
  localparam int unsigned SLOTS = 32;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic [VW-1:0] neg_full_scale;
  logic [VW-2:0] pos_full_scale;
  rgb_t          predicted_colors [SLOTS];
  logic [4:0]    rd_ptr;
  logic [4:0]    wr_ptr;
  int unsigned   stored;

  function automatic logic [63:0] magnitude(logic [VW-1:0] v);
    logic [VW-1:0] neg_v;
    neg_v = ~v + 1'b1;
    return v[VW-1] ? 64'(neg_v) : 64'(v);
  endfunction

  // restoring division, one quotient bit per step
  function automatic logic [63:0] limit_ratio(logic [63:0] mag, logic [63:0] lim);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = mag;
    if (lim == 0 || mag >= lim) return UNITY;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= lim) begin
        rem = rem - lim;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [7:0] level_to_byte(logic [63:0] lvl);
    logic [63:0] scaled;
    scaled = (lvl * 255 + (UNITY >> 1)) >> FB;
    return scaled[7:0];
  endfunction

  function automatic rgb_t sample_to_rgb(logic [VW-1:0] s, logic [VW-1:0] nlim,
                                         logic [VW-2:0] plim);
    logic [63:0] alpha, hs, frac, mid_gap, x, lr, lg, lb;
    rgb_t        c;
    if (s[VW-1]) begin
      alpha = limit_ratio(magnitude(s), magnitude(nlim));
      hs    = 2 * UNITY + 2 * alpha;
    end else begin
      alpha = limit_ratio(64'(s), 64'(plim));
      hs    = 2 * UNITY - 2 * alpha;
    end
    frac    = hs & (2 * UNITY - 1);
    mid_gap = (frac >= UNITY) ? frac - UNITY : UNITY - frac;
    x       = UNITY - mid_gap;
    if (hs <= UNITY) begin
      lr = UNITY; lg = x;     lb = '0;
    end else if (hs <= 2 * UNITY) begin
      lr = x;     lg = UNITY; lb = '0;
    end else if (hs <= 3 * UNITY) begin
      lr = '0;    lg = UNITY; lb = x;
    end else begin
      lr = '0;    lg = x;     lb = UNITY;
    end
    c.red   = level_to_byte(lr);
    c.green = level_to_byte(lg);
    c.blue  = level_to_byte(lb);
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      neg_full_scale = '0;
      pos_full_scale = '0;
      rd_ptr       = '0;
      wr_ptr       = '0;
      stored       = 0;
      fail_count_o = 0;
      pending_o    = 0;
      samples_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_NEG_LIMIT) neg_full_scale = pwdata[VW-1:0];
        else                           pos_full_scale = pwdata[VW-2:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (stored == 0) begin
          fail_count_o++;
          $display("%0t: unexpected color r=%0d g=%0d b=%0d", $time,
                   out_mon.red, out_mon.green, out_mon.blue);
        end else begin
          want   = predicted_colors[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          stored--;
          if (out_mon.red !== want.red) begin
            fail_count_o++;
            $display("%0t: red expected %0d actual %0d", $time, want.red, out_mon.red);
          end
          if (out_mon.green !== want.green) begin
            fail_count_o++;
            $display("%0t: green expected %0d actual %0d", $time, want.green,
                     out_mon.green);
          end
          if (out_mon.blue !== want.blue) begin
            fail_count_o++;
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_mon.blue);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (stored == SLOTS) begin
          fail_count_o++;
          $display("%0t: more than %0d colors in flight", $time, SLOTS);
        end else begin
          predicted_colors[wr_ptr] = sample_to_rgb(in_mon.sample_value, neg_full_scale,
                                                   pos_full_scale);
          wr_ptr = wr_ptr + 1'b1;
          stored++;
        end
        samples_o++;
      end
      pending_o = stored;
    end
  end

endmodule

// ===== tb/tb_diverging_curvature_colormap.sv =====
// top of the diverging colormap testbench: clock, reset, apb limit writes, sample
// stimulus, output back-pressure, watchdog and verdict
// depends on dcc_pkg, dcc_in_if, dcc_out_if, dcc_colormap_checker and the block itself

module tb_diverging_curvature_colormap;
  import dcc_pkg::*;

  // wait allowance for the result pipe, from the ratio width; the final wait adds margin
  localparam int unsigned PIPE_DEPTH   = RATIO_FRAC_BITS_DEF + 2;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam logic [31:0] MOST_NEG     = 32'h8000_0000;
  localparam logic [31:0] MOST_POS     = 32'h7fff_ffff;
  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dcc_in_if #(.VALUE_WIDTH(VALUE_WIDTH_DEF)) in_ch ();
  dcc_out_if out_ch ();

  int unsigned fail_count;
  int unsigned colors_pending;
  int unsigned samples_taken;
  int unsigned settings_used;
  int unsigned idle_cycles;
  int unsigned ready_stall;
  logic        idling_on;     // random gaps on both sides when set
  logic        color_taken;

  diverging_curvature_colormap DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  dcc_colormap_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (colors_pending),
    .samples_o    (samples_taken)
  );

  // 4 unit clock period
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side: after each taken color, ready may drop low for a random stall while idling_on is set
  always @(posedge clk_i) begin
    color_taken <= out_ch.valid && out_ch.ready;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (color_taken) ready_stall = idling_on ? $urandom_range(0, 15) : 0;
      if (ready_stall != 0) begin
        out_ch.ready <= 1'b0;
        ready_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles in a row with no request, color or register write
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one apb write: setup cycle, access cycle, then release
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // entered and left at a falling edge; valid stays high across back-to-back requests
  task automatic offer_sample(input logic [31:0] value);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every predicted color has been checked
  task automatic drain_colors();
    in_ch.valid <= 1'b0;
    while (colors_pending != 0) @(negedge clk_i);
  endtask

  // limits change only with the pipe empty
  task automatic set_limits(input logic [31:0] neg_lim, input logic [31:0] pos_lim);
    drain_colors();
    apb_write(REG_NEG_LIMIT, neg_lim);
    apb_write(REG_POS_LIMIT, pos_lim & MOST_POS);
    settings_used++;
  endtask

  // magnitude of random bit length, so small and huge limits both show up
  function automatic logic [31:0] random_span();
    int unsigned w;
    logic [31:0] v;
    w = $urandom_range(1, 31);
    v = $urandom;
    return v & ((32'd1 << w) - 1);
  endfunction

  // mostly samples scaled from the active limit, some full-range noise,
  // some tiny values and some right at the limit
  function automatic logic [31:0] pick_sample(input logic [63:0] neg_mag,
                                              input logic [63:0] pos_mag);
    logic        neg_side;
    logic [63:0] m;
    logic [31:0] t;
    neg_side = 1'($urandom_range(0, 1));
    m = neg_side ? neg_mag : pos_mag;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: m = 64'($urandom_range(0, 255));
      3: begin
        m = m + $urandom_range(0, 2);
        m = (m == 0) ? m : m - 1;
      end
      default: m = (m * $urandom_range(0, 1280)) >> 10;
    endcase
    if (neg_side) begin
      if (m > 64'(MOST_NEG)) m = 64'(MOST_NEG);
      t = m[31:0];
      return ~t + 1'b1;
    end
    if (m > 64'(MOST_POS)) m = 64'(MOST_POS);
    return m[31:0];
  endfunction

  initial begin
    logic [31:0] neg_lim;
    logic [31:0] pos_lim;
    logic [63:0] neg_mag;
    logic [63:0] pos_mag;

    // every input known from time zero
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    idling_on          = 1'b1;
    settings_used      = 0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // limits at reset are zero: zero is red, any positive red, any negative blue
    offer_sample(32'd0);
    offer_sample(32'd1);
    offer_sample(32'hffff_ffff);
    offer_sample(MOST_POS);
    offer_sample(MOST_NEG);

    // +-4.0 full scale: zero is green, half scale lands on the sector borders,
    // at and beyond full scale saturates, one lsb inside full scale on both signs
    set_limits(-(4 * ONE_Q16), 4 * ONE_Q16);
    offer_sample(32'd0);
    offer_sample(ONE_Q16);
    offer_sample(2 * ONE_Q16);
    offer_sample(4 * ONE_Q16);
    offer_sample(4 * ONE_Q16 - 1);
    offer_sample(MOST_POS);
    offer_sample(-ONE_Q16);
    offer_sample(-(2 * ONE_Q16));
    offer_sample(-(4 * ONE_Q16));
    offer_sample(-(4 * ONE_Q16) + 1);
    offer_sample(MOST_NEG);
    offer_sample(32'd1);
    offer_sample(32'hffff_ffff);

    // widest limits: most negative sample against most negative limit is exactly one
    set_limits(MOST_NEG, MOST_POS);
    offer_sample(MOST_NEG);
    offer_sample(32'hffff_ffff);
    offer_sample(MOST_POS);
    offer_sample(32'h4000_0000);
    offer_sample(32'hc000_0000);

    // positive neg_limit counts by its magnitude; tiny positive limit
    set_limits(3 * (ONE_Q16 >> 1), 32'd1);
    offer_sample(-(3 * (ONE_Q16 >> 2)));
    offer_sample(32'd0);
    offer_sample(32'd1);

    // random phases: a new pair of limits each time, every fourth phase runs
    // with no gaps on either side
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          neg_lim = '0;
          pos_lim = '0;
          neg_mag = '0;
        end
        1: begin
          neg_lim = MOST_NEG;
          pos_lim = MOST_POS;
          neg_mag = 64'(MOST_NEG);
        end
        default: begin
          neg_mag = 64'(random_span());
          pos_lim = random_span();
          // now and then a positive neg_limit, which counts by its magnitude
          neg_lim = ($urandom_range(0, 7) == 0) ? neg_mag[31:0] : -neg_mag[31:0];
        end
      endcase
      pos_mag = 64'(pos_lim);
      set_limits(neg_lim, pos_lim);
      idling_on = (p % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) offer_sample(pick_sample(neg_mag, pos_mag));
    end

    // let any stray color show up before the verdict
    drain_colors();
    repeat (PIPE_DEPTH + 8) @(negedge clk_i);

    $display("checked %0d samples under %0d limit settings plus the reset limits",
             samples_taken, settings_used);
    $display("limits covered zero, widest, positive neg_limit and random magnitudes");
    if (fail_count == 0 && colors_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
